### design/lz_pkg.sv
`timescale 1ns / 1ps
// lz_pkg: widths, reset values, register indexes and mul unit handshake types
// for the Lorenz Euler step block. No dependencies.
package lz_pkg;

    localparam int WORD_W   = 32;
    localparam int FRAC_W   = 24;
    localparam int COEF_W   = 31;
    localparam int STEP_W   = 21;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 3;

    // working width of products and sums, |value| < 2^40
    localparam int ACC_W    = 41;
    // multiplier: low slice of operand A times operand B magnitude
    localparam int MUL_LO_W = 33;
    localparam int MUL_HI_W = ACC_W - MUL_LO_W;
    localparam int MAG_B_W  = 32;
    localparam int PROD_W   = MUL_LO_W + MAG_B_W;
    localparam int SUM_W    = 64;

    localparam logic [COEF_W-1:0] COEF_A_RST = 31'd253872833;
    localparam logic [COEF_W-1:0] COEF_B_RST = 31'd547207355;
    localparam logic [COEF_W-1:0] COEF_C_RST = 31'd111349040;
    localparam logic [STEP_W-1:0] STEP_RST   = 21'd16777;
    localparam logic signed [WORD_W-1:0] POS_RST = 32'sd1677722;

    localparam logic [CFG_IDX_W-1:0] CFG_COEF_A = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_B = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_C = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_START_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_START_Y = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_START_Z = 3'd6;

    typedef struct packed {
        logic                     start;
        logic signed [ACC_W-1:0]  op_a;
        logic signed [WORD_W-1:0] op_b;
    } lz_mul_req_t;

    typedef struct packed {
        logic                     done;
        logic signed [ACC_W-1:0]  res;
    } lz_mul_rsp_t;

endpackage

### design/lz_mul.sv
`timescale 1ns / 1ps
// lz_mul: shared fixed-point multiplier, 33x32 array used on the low and then the high slice of A,
// rounds to nearest (ties away from zero) at FRAC_W. Depends on lz_pkg.
module lz_mul
    import lz_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  lz_mul_req_t req,
    output lz_mul_rsp_t rsp
);

    typedef enum logic [2:0] {
        MS_IDLE,
        MS_LO,
        MS_HI,
        MS_ADD,
        MS_RND
    } mstate_t;

    mstate_t              state_reg, state_next;
    logic [ACC_W-1:0]     mag_a_reg, mag_a_next;
    logic [MAG_B_W-1:0]   mag_b_reg, mag_b_next;
    logic                 neg_reg, neg_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;
    logic [SUM_W-1:0]     acc_reg, acc_next;
    logic signed [ACC_W-1:0] res_reg, res_next;
    logic                 done_reg, done_next;

    logic [MUL_LO_W-1:0]  mul_x;
    logic [PROD_W-1:0]    mul_p;
    logic [SUM_W-1:0]     rnd;
    logic [ACC_W-1:0]     rnd_mag;

    assign mul_x = (state_reg == MS_HI)
                 ? {{(MUL_LO_W-MUL_HI_W){1'b0}}, mag_a_reg[ACC_W-1:MUL_LO_W]}
                 : mag_a_reg[MUL_LO_W-1:0];
    assign mul_p = {{MAG_B_W{1'b0}}, mul_x} * {{MUL_LO_W{1'b0}}, mag_b_reg};

    assign rnd     = acc_reg + (SUM_W'(1) << (FRAC_W - 1));
    assign rnd_mag = ACC_W'(rnd >> FRAC_W);

    always_comb
    begin
        state_next = state_reg;
        mag_a_next = mag_a_reg;
        mag_b_next = mag_b_reg;
        neg_next   = neg_reg;
        prod_next  = prod_reg;
        acc_next   = acc_reg;
        res_next   = res_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            MS_IDLE:
            begin
                if (req.start)
                begin
                    mag_a_next = req.op_a[ACC_W-1] ? ACC_W'(-req.op_a) : ACC_W'(req.op_a);
                    mag_b_next = req.op_b[WORD_W-1] ? MAG_B_W'(-req.op_b)
                                                    : MAG_B_W'(req.op_b);
                    neg_next   = req.op_a[ACC_W-1] ^ req.op_b[WORD_W-1];
                    state_next = MS_LO;
                end
            end
            MS_LO:
            begin
                prod_next  = mul_p;
                state_next = MS_HI;
            end
            MS_HI:
            begin
                acc_next   = prod_reg[SUM_W-1:0];
                prod_next  = mul_p;
                state_next = (mag_a_reg[ACC_W-1:MUL_LO_W] != '0) ? MS_ADD : MS_RND;
            end
            MS_ADD:
            begin
                acc_next   = acc_reg + {prod_reg[SUM_W-MUL_LO_W-1:0], {MUL_LO_W{1'b0}}};
                state_next = MS_RND;
            end
            MS_RND:
            begin
                res_next   = neg_reg ? -$signed(rnd_mag) : $signed(rnd_mag);
                done_next  = 1'b1;
                state_next = MS_IDLE;
            end
            default:
            begin
                state_next = MS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MS_IDLE;
            done_reg  <= 1'b0;
            mag_a_reg <= '0;
            mag_b_reg <= '0;
            neg_reg   <= 1'b0;
            prod_reg  <= '0;
            acc_reg   <= '0;
            res_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            mag_a_reg <= mag_a_next;
            mag_b_reg <= mag_b_next;
            neg_reg   <= neg_next;
            prod_reg  <= prod_next;
            acc_reg   <= acc_next;
            res_reg   <= res_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.res  = res_reg;

endmodule

### design/lorenz_euler_step.sv
`timescale 1ns / 1ps
// lorenz_euler_step: one Euler step of the Lorenz system per input beat, or a reload.
// Step beat: eight products in turn on lz_mul; the three by dt take an extra add step
// when that operand exceeds 33 bits. Reload beat: the start point is sent out as is.
// One beat in flight; the output register holds a result while the next beat runs.
// Reset: async active low; point and registers go to their defaults at once.
module lorenz_euler_step
    import lz_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     reload,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [WORD_W-1:0] x_out,
    output logic signed [WORD_W-1:0] y_out,
    output logic signed [WORD_W-1:0] z_out,
    output logic                     overflow,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_W-1:0]         cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_AT,
        ST_PDT,
        ST_XZ,
        ST_BX,
        ST_SDY,
        ST_XY,
        ST_CZ,
        ST_SDZ,
        ST_UPD,
        ST_OUT
    } state_t;

    localparam int SAT_W = WORD_W + 1;
    localparam int UPD_W = ACC_W + 1;
    localparam int BIG_W = ACC_W + 2;

    logic [COEF_W-1:0]        coef_a_reg, coef_b_reg, coef_c_reg;
    logic [STEP_W-1:0]        step_reg;
    logic signed [WORD_W-1:0] start_x_reg, start_y_reg, start_z_reg;

    state_t                   state_reg, state_next;
    logic                     busy_reg, busy_next;
    logic signed [WORD_W-1:0] px_reg, px_next, py_reg, py_next, pz_reg, pz_next;
    logic signed [ACC_W-1:0]  s_reg, s_next;
    logic signed [ACC_W-1:0]  dx_reg, dx_next, dy_reg, dy_next, dz_reg, dz_next;
    logic                     flag_reg, flag_next;
    logic                     ov_reg, ov_next;
    logic signed [WORD_W-1:0] xo_reg, xo_next, yo_reg, yo_next, zo_reg, zo_next;
    logic                     ov_out_reg, ov_out_next;

    lz_mul_req_t              mreq;
    lz_mul_rsp_t              mrsp;
    logic signed [ACC_W-1:0]  ext_x, ext_y, ext_z;
    logic signed [BIG_W-1:0]  dy_sum;
    logic [SAT_W-1:0]         sat_x, sat_y, sat_z;

    function automatic logic [SAT_W-1:0] sat_add(input logic signed [WORD_W-1:0] p,
                                                 input logic signed [ACC_W-1:0]  d);
        logic signed [UPD_W-1:0] sum;
        logic                    fits;
        sum  = UPD_W'(p) + UPD_W'(d);
        fits = (sum[UPD_W-1:WORD_W-1] == '0) || (sum[UPD_W-1:WORD_W-1] == '1);
        if (fits)
            return {1'b0, sum[WORD_W-1:0]};
        else if (sum[UPD_W-1])
            return {1'b1, 1'b1, {(WORD_W-1){1'b0}}};
        else
            return {1'b1, 1'b0, {(WORD_W-1){1'b1}}};
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_a_reg  <= COEF_A_RST;
            coef_b_reg  <= COEF_B_RST;
            coef_c_reg  <= COEF_C_RST;
            step_reg    <= STEP_RST;
            start_x_reg <= POS_RST;
            start_y_reg <= POS_RST;
            start_z_reg <= POS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_COEF_A:  coef_a_reg  <= cfg_data[COEF_W-1:0];
                CFG_COEF_B:  coef_b_reg  <= cfg_data[COEF_W-1:0];
                CFG_COEF_C:  coef_c_reg  <= cfg_data[COEF_W-1:0];
                CFG_STEP:    step_reg    <= cfg_data[STEP_W-1:0];
                CFG_START_X: start_x_reg <= $signed(cfg_data[WORD_W-1:0]);
                CFG_START_Y: start_y_reg <= $signed(cfg_data[WORD_W-1:0]);
                CFG_START_Z: start_z_reg <= $signed(cfg_data[WORD_W-1:0]);
                default:     ;
            endcase
        end
    end

    assign ext_x = ACC_W'(px_reg);
    assign ext_y = ACC_W'(py_reg);
    assign ext_z = ACC_W'(pz_reg);

    assign dy_sum = BIG_W'(s_reg) + BIG_W'(mrsp.res) - BIG_W'(py_reg);

    assign sat_x = sat_add(px_reg, dx_reg);
    assign sat_y = sat_add(py_reg, dy_reg);
    assign sat_z = sat_add(pz_reg, dz_reg);

    // operand routing for the shared multiplier
    always_comb
    begin
        mreq.start = 1'b0;
        mreq.op_a  = s_reg;
        mreq.op_b  = WORD_W'(step_reg);
        unique case (state_reg)
            ST_AT:
            begin
                mreq.start = !busy_reg;
                mreq.op_b  = WORD_W'(coef_a_reg);
            end
            ST_PDT, ST_SDY, ST_SDZ:
            begin
                mreq.start = !busy_reg;
            end
            ST_XZ:
            begin
                mreq.start = !busy_reg;
                mreq.op_a  = ext_x;
                mreq.op_b  = pz_reg;
            end
            ST_BX:
            begin
                mreq.start = !busy_reg;
                mreq.op_a  = ext_x;
                mreq.op_b  = WORD_W'(coef_b_reg);
            end
            ST_XY:
            begin
                mreq.start = !busy_reg;
                mreq.op_a  = ext_x;
                mreq.op_b  = py_reg;
            end
            ST_CZ:
            begin
                mreq.start = !busy_reg;
                mreq.op_a  = ext_z;
                mreq.op_b  = WORD_W'(coef_c_reg);
            end
            default:
            begin
                mreq.start = 1'b0;
            end
        endcase
    end

    lz_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mreq),
        .rsp   (mrsp)
    );

    always_comb
    begin
        state_next  = state_reg;
        busy_next   = busy_reg;
        px_next     = px_reg;
        py_next     = py_reg;
        pz_next     = pz_reg;
        s_next      = s_reg;
        dx_next     = dx_reg;
        dy_next     = dy_reg;
        dz_next     = dz_reg;
        flag_next   = flag_reg;
        ov_next     = ov_reg;
        xo_next     = xo_reg;
        yo_next     = yo_reg;
        zo_next     = zo_reg;
        ov_out_next = ov_out_reg;

        if (ov_reg && out_ready)
            ov_next = 1'b0;

        if (mreq.start)
            busy_next = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (reload)
                    begin
                        px_next    = start_x_reg;
                        py_next    = start_y_reg;
                        pz_next    = start_z_reg;
                        flag_next  = 1'b0;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        s_next     = ext_y - ext_x;
                        state_next = ST_AT;
                    end
                end
            end
            ST_AT:
            begin
                if (mrsp.done)
                begin
                    busy_next  = 1'b0;
                    s_next     = mrsp.res;
                    state_next = ST_PDT;
                end
            end
            ST_PDT:
            begin
                if (mrsp.done)
                begin
                    busy_next  = 1'b0;
                    dx_next    = mrsp.res;
                    state_next = ST_XZ;
                end
            end
            ST_XZ:
            begin
                if (mrsp.done)
                begin
                    busy_next  = 1'b0;
                    s_next     = -mrsp.res;
                    state_next = ST_BX;
                end
            end
            ST_BX:
            begin
                if (mrsp.done)
                begin
                    busy_next  = 1'b0;
                    s_next     = dy_sum[ACC_W-1:0];
                    state_next = ST_SDY;
                end
            end
            ST_SDY:
            begin
                if (mrsp.done)
                begin
                    busy_next  = 1'b0;
                    dy_next    = mrsp.res;
                    state_next = ST_XY;
                end
            end
            ST_XY:
            begin
                if (mrsp.done)
                begin
                    busy_next  = 1'b0;
                    s_next     = mrsp.res;
                    state_next = ST_CZ;
                end
            end
            ST_CZ:
            begin
                if (mrsp.done)
                begin
                    busy_next  = 1'b0;
                    s_next     = s_reg - mrsp.res;
                    state_next = ST_SDZ;
                end
            end
            ST_SDZ:
            begin
                if (mrsp.done)
                begin
                    busy_next  = 1'b0;
                    dz_next    = mrsp.res;
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                px_next    = sat_x[WORD_W-1:0];
                py_next    = sat_y[WORD_W-1:0];
                pz_next    = sat_z[WORD_W-1:0];
                flag_next  = sat_x[WORD_W] | sat_y[WORD_W] | sat_z[WORD_W];
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!ov_reg || out_ready)
                begin
                    xo_next     = px_reg;
                    yo_next     = py_reg;
                    zo_next     = pz_reg;
                    ov_out_next = flag_reg;
                    ov_next     = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            busy_reg   <= 1'b0;
            px_reg     <= POS_RST;
            py_reg     <= POS_RST;
            pz_reg     <= POS_RST;
            flag_reg   <= 1'b0;
            ov_reg     <= 1'b0;
            s_reg      <= '0;
            dx_reg     <= '0;
            dy_reg     <= '0;
            dz_reg     <= '0;
            xo_reg     <= '0;
            yo_reg     <= '0;
            zo_reg     <= '0;
            ov_out_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            busy_reg   <= busy_next;
            px_reg     <= px_next;
            py_reg     <= py_next;
            pz_reg     <= pz_next;
            flag_reg   <= flag_next;
            ov_reg     <= ov_next;
            s_reg      <= s_next;
            dx_reg     <= dx_next;
            dy_reg     <= dy_next;
            dz_reg     <= dz_next;
            xo_reg     <= xo_next;
            yo_reg     <= yo_next;
            zo_reg     <= zo_next;
            ov_out_reg <= ov_out_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = ov_reg;
    assign x_out     = xo_reg;
    assign y_out     = yo_reg;
    assign z_out     = zo_reg;
    assign overflow  = ov_out_reg;

endmodule

### design/lz_chk.sv
`timescale 1ns / 1ps
// lz_chk: port-level checks on lorenz_euler_step, attached by bind.
// Depends on lz_pkg and the top level's port names.
module lz_chk
    import lz_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_ready,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic signed [WORD_W-1:0] x_out,
    input logic signed [WORD_W-1:0] y_out,
    input logic signed [WORD_W-1:0] z_out,
    input logic                     overflow
);

    // one beat in flight: ready drops right after an accepted beat
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("in_ready still high after accepted beat");

    // ready only drops because a beat was taken
    a_ready_fall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_ready) |-> $past(in_valid))
        else $error("in_ready fell without an input beat");

    // a new result shows up together with the block returning to idle
    a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
        else $error("result raised while block still busy");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(x_out) && $stable(y_out)
                                       && $stable(z_out) && $stable(overflow)))
        else $error("stalled output beat changed");

endmodule

bind lorenz_euler_step lz_chk u_lz_chk (.*);
